/* src/cma_pkg.sv */
// Shared types, widths and the reciprocal table of the centered moving average block.
// No dependencies; compile first.
package cma_pkg;

  localparam int MAX_HALF_WINDOW = 15;
  localparam int RING_DEPTH      = 32;
  localparam int H_CAP = (MAX_HALF_WINDOW < (RING_DEPTH - 1) / 2) ?
                         MAX_HALF_WINDOW : (RING_DEPTH - 1) / 2;

  localparam int PRESS_W = 16;
  localparam int COORD_W = 16;
  localparam int HW_W    = 4;
  localparam int SUM_W   = 21;
  localparam int AGE_W   = $clog2(RING_DEPTH);
  localparam int PEND_W  = $clog2(H_CAP + 2);
  localparam int CNT_W   = $clog2(2 * H_CAP + 2);
  localparam int FILL_W  = 5;
  localparam logic [FILL_W-1:0] FILL_MAX = '1;

  // APB
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_HALF_WINDOW = '0;
  localparam logic [HW_W-1:0] HALF_WINDOW_RST = HW_W'(2);

  // floor(2^SUM_W / c), c = 1..31; entry 0 is never used
  localparam int RCP_W   = SUM_W + 1;
  localparam int RCP_ONE = 1 << SUM_W;
  localparam logic [RCP_W-1:0] RECIP_TBL [32] = '{
    RCP_W'(0),            RCP_W'(RCP_ONE / 1),  RCP_W'(RCP_ONE / 2),  RCP_W'(RCP_ONE / 3),
    RCP_W'(RCP_ONE / 4),  RCP_W'(RCP_ONE / 5),  RCP_W'(RCP_ONE / 6),  RCP_W'(RCP_ONE / 7),
    RCP_W'(RCP_ONE / 8),  RCP_W'(RCP_ONE / 9),  RCP_W'(RCP_ONE / 10), RCP_W'(RCP_ONE / 11),
    RCP_W'(RCP_ONE / 12), RCP_W'(RCP_ONE / 13), RCP_W'(RCP_ONE / 14), RCP_W'(RCP_ONE / 15),
    RCP_W'(RCP_ONE / 16), RCP_W'(RCP_ONE / 17), RCP_W'(RCP_ONE / 18), RCP_W'(RCP_ONE / 19),
    RCP_W'(RCP_ONE / 20), RCP_W'(RCP_ONE / 21), RCP_W'(RCP_ONE / 22), RCP_W'(RCP_ONE / 23),
    RCP_W'(RCP_ONE / 24), RCP_W'(RCP_ONE / 25), RCP_W'(RCP_ONE / 26), RCP_W'(RCP_ONE / 27),
    RCP_W'(RCP_ONE / 28), RCP_W'(RCP_ONE / 29), RCP_W'(RCP_ONE / 30), RCP_W'(RCP_ONE / 31)
  };

  typedef logic [PRESS_W-1:0]        press_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  // one chain cell: running stroke sum up to this sample, plus its position
  typedef struct packed {
    logic [SUM_W-1:0] csum;
    coord_t           x;
    coord_t           y;
  } cell_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } div_req_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] quot;
  } div_rsp_t;

endpackage

/* src/cma_stream_if.sv */
// Valid/ready stream interfaces for sample words in and result words out.
// Depends on cma_pkg.
interface cma_sample_if;
  logic            valid;
  logic            ready;
  cma_pkg::press_t pressure_in;
  cma_pkg::coord_t x_in;
  cma_pkg::coord_t y_in;
  logic            stroke_end;

  modport source (output valid, pressure_in, x_in, y_in, stroke_end, input ready);
  modport sink   (input valid, pressure_in, x_in, y_in, stroke_end, output ready);
endinterface

interface cma_result_if;
  logic            valid;
  logic            ready;
  cma_pkg::press_t pressure_out;
  cma_pkg::coord_t x_out;
  cma_pkg::coord_t y_out;
  logic            last_out;

  modport source (output valid, pressure_out, x_out, y_out, last_out, input ready);
  modport sink   (input valid, pressure_out, x_out, y_out, last_out, output ready);
endinterface

/* src/centered_moving_average_clamped.sv */
// Top level: centered moving average of pen pressure with the window clamped at stroke ends.
// Depends on cma_pkg, cma_stream_if, cma_cell and cma_div.
//
//   port      dir  handshake      word
//   sample_i  in   valid/ready    pressure_in, x_in, y_in, stroke_end
//   result_o  out  valid/ready    pressure_out, x_out, y_out, last_out
//   APB       in   psel/penable   half_window at byte address 0 (pready tied high)
//
// An item is accepted, then passes the emit check; each result it releases takes three
// reads of the chain through its single read mux, the divider, a load of the output
// register, and the next emit check.
// A stalled output holds the sequencer in its load state; one finished result may
// wait in the output register while the next sample is taken.
// Reset clears control state only; the chain contents are undefined until written.
module centered_moving_average_clamped (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  cma_sample_if.sink                  sample_i,
  cma_result_if.source                result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cma_pkg::PADDR_W-1:0] paddr,
  input  logic [cma_pkg::PDATA_W-1:0] pwdata,
  output logic [cma_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import cma_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;  // decide whether the oldest pending sample leaves
  localparam logic [2:0] ST_RD_HI  = 3'd2;  // running sum at the window's newest sample
  localparam logic [2:0] ST_RD_MID = 3'd3;  // position of the centre sample
  localparam logic [2:0] ST_RD_LO  = 3'd4;  // running sum just before the window, start divide
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_PUSH   = 3'd6;

  logic [2:0] state_q, state_d;

  // config
  logic [HW_W-1:0] hw_q, hw_d;
  logic [HW_W-1:0] eff_h;
  logic            cfg_wr;

  // stroke bookkeeping
  logic [PEND_W-1:0] pend_q, pend_d;    // samples whose result has not left yet
  logic [FILL_W-1:0] fill_q, fill_d;    // results already out in this stroke, saturating
  logic [SUM_W-1:0]  clast_q, clast_d;  // running sum of the newest sample, zero at stroke start
  logic              end_q, end_d;

  // per-result plan, ages count from the newest sample (age 0)
  logic [AGE_W-1:0] hi_age_q, hi_age_d;
  logic [AGE_W-1:0] mid_age_q, mid_age_d;
  logic [AGE_W-1:0] lo_age_q, lo_age_d;
  logic             zero_lo_q, zero_lo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last_q, last_d;

  logic [SUM_W-1:0] c_hi_q, c_hi_d;
  coord_t           x_q, x_d, y_q, y_d;
  press_t           quot_q, quot_d;

  // output register
  logic   out_valid_q, out_valid_d;
  press_t out_p_q, out_p_d;
  coord_t out_x_q, out_x_d, out_y_q, out_y_d;
  logic   out_last_q, out_last_d;
  logic   out_free;

  // sample chain
  cell_t            cell_q [RING_DEPTH];
  cell_t            new_cell;
  cell_t            rd_cell;
  logic [AGE_W-1:0] sel_age;
  logic             accept;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // emit-check arithmetic
  logic [PEND_W-1:0] pm1;
  logic [HW_W-1:0]   left4, right4;
  logic              fill_le_h;
  logic              emit;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_HALF_WINDOW);
  assign hw_d   = cfg_wr ? pwdata[HW_W-1:0] : hw_q;
  assign prdata = (paddr[PADDR_W-1:2] == REG_HALF_WINDOW) ? PDATA_W'(hw_q) : '0;
  assign eff_h  = (hw_q > HW_W'(H_CAP)) ? HW_W'(H_CAP) : hw_q;

  // ---------------------------------------------------------------- chain of cells
  // cell 0 takes the new sample; every cell hands its word one place older
  assign accept         = sample_i.valid && sample_i.ready;
  assign new_cell.csum  = clast_q + SUM_W'(sample_i.pressure_in);
  assign new_cell.x     = sample_i.x_in;
  assign new_cell.y     = sample_i.y_in;

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      cma_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (accept),
        .d_i     (new_cell),
        .q_o     (cell_q[i])
      );
    end else begin : g_body
      cma_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (accept),
        .d_i     (cell_q[i-1]),
        .q_o     (cell_q[i])
      );
    end
  end

  // one read tap, steered by the sequencer
  always_comb begin
    unique case (state_q)
      ST_RD_HI:  sel_age = hi_age_q;
      ST_RD_MID: sel_age = mid_age_q;
      default:   sel_age = lo_age_q;
    endcase
  end
  assign rd_cell = cell_q[sel_age];

  // ---------------------------------------------------------------- divider
  assign div_req.valid = (state_q == ST_RD_LO);
  assign div_req.sum   = c_hi_q - (zero_lo_q ? SUM_W'(0) : rd_cell.csum);
  assign div_req.count = cnt_q;

  cma_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------- emit check
  // Window of the oldest pending sample (age pend-1): right side is h, or what is
  // left of the stroke on a flush; left side is cut at the stroke's first sample,
  // in which case nothing is subtracted from the running sum.
  assign pm1       = pend_q - PEND_W'(1);
  assign fill_le_h = (fill_q <= FILL_W'(eff_h));
  assign left4     = fill_le_h ? fill_q[HW_W-1:0] : eff_h;
  assign right4    = (end_q && (pm1 < PEND_W'(eff_h))) ? pm1[HW_W-1:0] : eff_h;
  assign emit      = end_q ? (pend_q != '0) : (pend_q > PEND_W'(eff_h));

  assign out_free = !out_valid_q || result_o.ready;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d   = state_q;
    pend_d    = pend_q;
    fill_d    = fill_q;
    clast_d   = clast_q;
    end_d     = end_q;
    hi_age_d  = hi_age_q;
    mid_age_d = mid_age_q;
    lo_age_d  = lo_age_q;
    zero_lo_d = zero_lo_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    c_hi_d    = c_hi_q;
    x_d       = x_q;
    y_d       = y_q;
    quot_d    = quot_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_p_d     = out_p_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          clast_d = new_cell.csum;
          pend_d  = pend_q + PEND_W'(1);
          end_d   = sample_i.stroke_end;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (emit) begin
          hi_age_d  = AGE_W'(pm1) - AGE_W'(right4);
          mid_age_d = AGE_W'(pm1);
          lo_age_d  = AGE_W'(pend_q) + AGE_W'(left4);
          zero_lo_d = fill_le_h;
          cnt_d     = CNT_W'(left4) + CNT_W'(right4) + CNT_W'(1);
          last_d    = end_q && (pend_q == PEND_W'(1));
          state_d   = ST_RD_HI;
        end else begin
          if (end_q) begin
            // stroke done: next sample opens a new one
            fill_d  = '0;
            clast_d = '0;
            end_d   = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      ST_RD_HI: begin
        c_hi_d  = rd_cell.csum;
        state_d = ST_RD_MID;
      end
      ST_RD_MID: begin
        x_d     = rd_cell.x;
        y_d     = rd_cell.y;
        state_d = ST_RD_LO;
      end
      ST_RD_LO: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.valid) begin
          quot_d  = div_rsp.quot[PRESS_W-1:0];
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_p_d     = quot_q;
          out_x_d     = x_q;
          out_y_d     = y_q;
          out_last_d  = last_q;
          pend_d      = pend_q - PEND_W'(1);
          fill_d      = (fill_q == FILL_MAX) ? fill_q : fill_q + FILL_W'(1);
          state_d     = ST_CHECK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hw_q        <= HALF_WINDOW_RST;
      pend_q      <= '0;
      fill_q      <= '0;
      clast_q     <= '0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hw_q        <= hw_d;
      pend_q      <= pend_d;
      fill_q      <= fill_d;
      clast_q     <= clast_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_age_q   <= hi_age_d;
    mid_age_q  <= mid_age_d;
    lo_age_q   <= lo_age_d;
    zero_lo_q  <= zero_lo_d;
    cnt_q      <= cnt_d;
    last_q     <= last_d;
    c_hi_q     <= c_hi_d;
    x_q        <= x_d;
    y_q        <= y_d;
    quot_q     <= quot_d;
    out_p_q    <= out_p_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_last_q <= out_last_d;
  end

  // ---------------------------------------------------------------- ports
  assign sample_i.ready        = (state_q == ST_IDLE);
  assign result_o.valid        = out_valid_q;
  assign result_o.pressure_out = out_p_q;
  assign result_o.x_out        = out_x_q;
  assign result_o.y_out        = out_y_q;
  assign result_o.last_out     = out_last_q;

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PEND_W'(H_CAP + 1))
    else $error("pending count beyond window reach");

  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_CHECK))
    else $error("accepted sample not followed by emit check");

  a_div_rsp_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.valid |-> (state_q == ST_DIV))
    else $error("divider result outside wait state");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_PUSH) && out_free && last_q) |=> (pend_q == '0))
    else $error("samples left pending after last result");
`endif

endmodule

/* src/cma_cell.sv */
// One storage cell of the sample chain; loads its neighbor's word on shift.
// Depends on cma_pkg.
module cma_cell (
  input  logic           clk_i,
  input  logic           shift_i,
  input  cma_pkg::cell_t d_i,
  output cma_pkg::cell_t q_o
);
  import cma_pkg::*;

  cell_t data_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= d_i;
    end
  end

  assign q_o = data_q;

endmodule

/* src/cma_div.sv */
// Four-stage divider: window sum by sample count via reciprocal table plus one correction.
// Depends on cma_pkg.
module cma_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cma_pkg::div_req_t req_i,
  output cma_pkg::div_rsp_t rsp_o
);
  import cma_pkg::*;

  localparam int PROD_W = SUM_W + RCP_W;
  localparam int QC_W   = SUM_W + CNT_W;

  logic v1_q, v2_q, v3_q, v4_q;

  logic [SUM_W-1:0] sum1_q, sum2_q, sum3_q;
  logic [CNT_W-1:0] cnt1_q, cnt2_q, cnt3_q;
  logic [RCP_W-1:0] rcp1_q;
  logic [SUM_W-1:0] q0_2_q, q0_3_q, quot_q;
  logic [QC_W-1:0]  qc3_q;

  logic [PROD_W-1:0] prod;
  logic [QC_W-1:0]   qc;
  logic [SUM_W-1:0]  rem;
  logic              bump;

  // q0 is the quotient or one short of it
  assign prod = PROD_W'(sum1_q) * PROD_W'(rcp1_q);
  assign qc   = QC_W'(q0_2_q) * QC_W'(cnt2_q);
  assign rem  = sum3_q - qc3_q[SUM_W-1:0];
  assign bump = (rem >= SUM_W'(cnt3_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum1_q <= req_i.sum;
    cnt1_q <= req_i.count;
    rcp1_q <= RECIP_TBL[req_i.count];

    sum2_q <= sum1_q;
    cnt2_q <= cnt1_q;
    q0_2_q <= prod[SUM_W +: SUM_W];

    sum3_q <= sum2_q;
    cnt3_q <= cnt2_q;
    q0_3_q <= q0_2_q;
    qc3_q  <= qc;

    quot_q <= bump ? (q0_3_q + SUM_W'(1)) : q0_3_q;
  end

  assign rsp_o.valid = v4_q;
  assign rsp_o.quot  = quot_q;

endmodule
